/* design/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the battery charge gauge
// Field widths, register map, voltage table segments and the controller to
// datapath command and status words.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// field widths
	localparam int CAP_W    = 16;
	localparam int DB_W     = 8;
	localparam int VBUS_W   = 15;
	localparam int VBAT_W   = 13;
	localparam int IVL_W    = 6;
	localparam int IBAT_W   = 13;
	localparam int PCT_W    = 14;
	localparam int CHG_W    = 28;
	localparam int CAP36_W  = 22;
	localparam int NUM_W    = 14;
	localparam int STEP_W   = IBAT_W + IVL_W + 1;
	localparam int PROD_W   = 42;

	// register map
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int RIDX_W   = 3;
	localparam logic [RIDX_W-1:0] REG_CAPACITY = 3'd0;
	localparam logic [RIDX_W-1:0] REG_DEADBAND = 3'd1;
	localparam logic [RIDX_W-1:0] REG_VBUS     = 3'd2;
	localparam logic [RIDX_W-1:0] REG_VBAT     = 3'd3;
	localparam logic [RIDX_W-1:0] REG_INTERVAL = 3'd4;

	// reset values
	localparam logic [CAP_W-1:0]  CAP_RST  = 16'd210;
	localparam logic [DB_W-1:0]   DB_RST   = 8'd8;
	localparam logic [VBUS_W-1:0] VBUS_RST = 15'd4500;
	localparam logic [VBAT_W-1:0] VBAT_RST = 13'd4150;
	localparam logic [IVL_W-1:0]  IVL_RST  = 6'd1;

	// scaling
	localparam logic [11:0]      MAS_PER_MAH = 12'd3600;
	localparam logic [5:0]       MAS_PER_PCT = 6'd36;
	localparam logic [PCT_W-1:0] PCT_FULL    = 14'd10000;
	localparam logic [VBAT_W-1:0] TBL_TOP_MV = 13'd4200;
	localparam logic [VBAT_W-1:0] TBL_BOT_MV = 13'd3000;

	// divider step counts
	localparam int DCNT_W = 5;
	localparam logic [DCNT_W-1:0] DIV_LONG_STEPS  = 5'd28;
	localparam logic [DCNT_W-1:0] DIV_SHORT_STEPS = 5'd14;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity_mah;
		logic [DB_W-1:0]   deadband_ma;
		logic [VBUS_W-1:0] full_vbus_mv;
		logic [VBAT_W-1:0] full_vbat_mv;
		logic [IVL_W-1:0]  interval_s;
	} cfg_t;

	typedef struct packed {
		logic latch;     // capture input word
		logic prep;      // full scale, table numerator, current step
		logic seed_mul;  // cap36 * numerator
		logic div_go;    // start divider
		logic div_long;  // 28-bit quotient (seed) vs 14-bit (percent)
		logic commit;    // update stored charge
		logic pct_mul;   // charge * 10000
		logic load_out;  // fill output register
	} cmd_t;

	typedef struct packed {
		logic seed_div;  // init word needs table interpolation
		logic full_zero; // capacity is zero
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [VBAT_W-1:0] v0;
		logic [8:0]        span;
		logic [6:0]        p0;
		logic [4:0]        dp;
	} seg_t;

	// table segment holding v (lower point v0, span, percent at v0, percent rise)
	function automatic seg_t seg_lookup(input logic [VBAT_W-1:0] v);
		seg_t s;
		if (v >= 13'd4100)      s = '{13'd4100, 9'd100, 7'd90, 5'd10};
		else if (v >= 13'd4000) s = '{13'd4000, 9'd100, 7'd80, 5'd10};
		else if (v >= 13'd3900) s = '{13'd3900, 9'd100, 7'd70, 5'd10};
		else if (v >= 13'd3800) s = '{13'd3800, 9'd100, 7'd60, 5'd10};
		else if (v >= 13'd3700) s = '{13'd3700, 9'd100, 7'd40, 5'd20};
		else if (v >= 13'd3600) s = '{13'd3600, 9'd100, 7'd20, 5'd20};
		else if (v >= 13'd3500) s = '{13'd3500, 9'd100, 7'd10, 5'd10};
		else if (v >= 13'd3300) s = '{13'd3300, 9'd200, 7'd5,  5'd5};
		else                    s = '{13'd3000, 9'd300, 7'd0,  5'd5};
		return s;
	endfunction

endpackage

/* design/bcc_div.sv */
// ----------------------------------------------------------------------------
// bcc_div: restoring divider, one quotient bit per cycle
// Long mode gives a 28-bit quotient, short mode a 14-bit one; the caller
// guarantees the quotient fits.
// ----------------------------------------------------------------------------
module bcc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           long_mode,
	input  logic [bcc_pkg::PROD_W-1:0]     dividend,
	input  logic [bcc_pkg::CHG_W-1:0]      divisor,
	output logic                           done,
	output logic [bcc_pkg::CHG_W-1:0]      quotient
);

	logic                          run_q;
	logic                          done_q;
	logic [bcc_pkg::DCNT_W-1:0]    cnt_q;
	logic [bcc_pkg::CHG_W-1:0]     rem_q;
	logic [bcc_pkg::CHG_W-1:0]     lo_q;
	logic [bcc_pkg::CHG_W-1:0]     quo_q;
	logic [bcc_pkg::CHG_W-1:0]     dvs_q;
	logic [bcc_pkg::CHG_W:0]       trial;
	logic [bcc_pkg::CHG_W:0]       diff;
	logic                          ge;

	assign trial = {rem_q, lo_q[bcc_pkg::CHG_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= long_mode ? bcc_pkg::DIV_LONG_STEPS : bcc_pkg::DIV_SHORT_STEPS;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			quo_q <= '0;
			if (long_mode) begin
				rem_q <= {14'd0, dividend[41:28]};
				lo_q  <= dividend[27:0];
			end else begin
				rem_q <= dividend[41:14];
				lo_q  <= {dividend[13:0], 14'd0};
			end
		end else if (run_q) begin
			rem_q <= ge ? diff[bcc_pkg::CHG_W-1:0] : trial[bcc_pkg::CHG_W-1:0];
			lo_q  <= {lo_q[bcc_pkg::CHG_W-2:0], 1'b0};
			quo_q <= {quo_q[bcc_pkg::CHG_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/bcc_dp.sv */
// ----------------------------------------------------------------------------
// bcc_dp: charge gauge datapath
// Input capture, multipliers, shared divider, charge accumulator, output word.
// ----------------------------------------------------------------------------
module bcc_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcc_pkg::cfg_t               cfg,
	input  bcc_pkg::cmd_t               cmd,
	output bcc_pkg::sts_t               sts,
	input  logic                        kind,
	input  logic [bcc_pkg::VBAT_W-1:0]  vbat_mv,
	input  logic                        vbat_read_ok,
	input  logic [bcc_pkg::VBUS_W-1:0]  vbus_mv,
	input  logic [bcc_pkg::IBAT_W-1:0]  ibat_ma,
	input  logic                        charger_idle,
	output logic [bcc_pkg::PCT_W-1:0]   percent_x100,
	output logic [bcc_pkg::CHG_W-1:0]   charge_mas,
	output logic                        forced_full
);

	// captured word
	logic                        kind_q;
	logic [bcc_pkg::VBAT_W-1:0]  vbat_q;
	logic                        ok_q;
	logic [bcc_pkg::VBUS_W-1:0]  vbus_q;
	logic [bcc_pkg::IBAT_W-1:0]  ibat_q;
	logic                        idle_q;

	// prepared operands
	logic [bcc_pkg::CHG_W-1:0]   full_q;
	logic [bcc_pkg::CAP36_W-1:0] cap36_q;
	logic [bcc_pkg::NUM_W-1:0]   num_q;
	logic signed [bcc_pkg::STEP_W-1:0] step_q;
	logic                        forced_q;
	logic [bcc_pkg::PROD_W-1:0]  prod_q;
	logic [bcc_pkg::CHG_W-1:0]   charge_q;

	logic [bcc_pkg::PCT_W-1:0]   pct_o_q;
	logic [bcc_pkg::CHG_W-1:0]   chg_o_q;
	logic                        frc_o_q;

	bcc_pkg::seg_t               seg;
	logic [bcc_pkg::VBAT_W-1:0]  dv;
	logic [15:0]                 num_wide;
	logic [bcc_pkg::IBAT_W-1:0]  mag;
	logic signed [bcc_pkg::IBAT_W-1:0] cur_db;
	logic                        above_top;
	logic                        below_bot;
	logic signed [29:0]          sum;
	logic [bcc_pkg::CHG_W-1:0]   charge_d;
	logic [bcc_pkg::CHG_W-1:0]   quo;
	logic                        div_done;
	logic [bcc_pkg::PROD_W-1:0]  div_dividend;
	logic [bcc_pkg::CHG_W-1:0]   div_divisor;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			vbat_q <= vbat_mv;
			ok_q   <= vbat_read_ok;
			vbus_q <= vbus_mv;
			ibat_q <= ibat_ma;
			idle_q <= charger_idle;
		end
	end

	// table segment and interpolation numerator
	assign seg       = bcc_pkg::seg_lookup(vbat_q);
	assign dv        = vbat_q - seg.v0;
	assign num_wide  = 16'(seg.p0 * seg.span) + 16'(dv[8:0] * seg.dp);
	assign above_top = vbat_q >= bcc_pkg::TBL_TOP_MV;
	assign below_bot = vbat_q <= bcc_pkg::TBL_BOT_MV;

	// deadband
	assign mag    = ibat_q[bcc_pkg::IBAT_W-1] ? (~ibat_q + 13'd1) : ibat_q;
	assign cur_db = (mag < {5'd0, cfg.deadband_ma}) ? '0 : $signed(ibat_q);

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			full_q   <= 28'(cfg.capacity_mah * bcc_pkg::MAS_PER_MAH);
			cap36_q  <= 22'(cfg.capacity_mah * bcc_pkg::MAS_PER_PCT);
			num_q    <= num_wide[bcc_pkg::NUM_W-1:0];
			step_q   <= cur_db * $signed({1'b0, cfg.interval_s});
			forced_q <= kind_q && idle_q && (vbus_q > cfg.full_vbus_mv)
				&& (vbat_q > cfg.full_vbat_mv);
		end
		if (cmd.seed_mul) begin
			prod_q <= 42'(cap36_q * num_q);
		end else if (cmd.pct_mul) begin
			prod_q <= 42'(charge_q * bcc_pkg::PCT_FULL);
		end
	end

	// divider operands: seed is product / span, percent is product / full
	assign div_dividend = cmd.div_long ? {7'd0, prod_q[34:0]} : prod_q;
	assign div_divisor  = cmd.div_long ? {19'd0, seg.span} : full_q;

	bcc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_go),
		.long_mode (cmd.div_long),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (quo)
	);

	// next charge
	assign sum = $signed({2'b00, charge_q}) + $signed({{10{step_q[bcc_pkg::STEP_W-1]}}, step_q});

	always_comb begin
		if (!kind_q) begin
			if (!ok_q)          charge_d = {1'b0, full_q[bcc_pkg::CHG_W-1:1]};
			else if (above_top) charge_d = full_q;
			else if (below_bot) charge_d = '0;
			else if (quo > full_q) charge_d = full_q;
			else                charge_d = quo;
		end else begin
			if (forced_q)                      charge_d = full_q;
			else if (sum[29])                  charge_d = '0;
			else if (sum[28:0] > {1'b0, full_q}) charge_d = full_q;
			else                               charge_d = sum[bcc_pkg::CHG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_q <= '0;
		end else if (cmd.commit) begin
			charge_q <= charge_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			chg_o_q <= charge_q;
			frc_o_q <= forced_q;
			if (full_q == '0)
				pct_o_q <= '0;
			else if (quo > {14'd0, bcc_pkg::PCT_FULL})
				pct_o_q <= bcc_pkg::PCT_FULL;
			else
				pct_o_q <= quo[bcc_pkg::PCT_W-1:0];
		end
	end

	assign sts.seed_div  = !kind_q && ok_q && !above_top && !below_bot;
	assign sts.full_zero = (full_q == '0);
	assign sts.div_done  = div_done;

	assign percent_x100 = pct_o_q;
	assign charge_mas   = chg_o_q;
	assign forced_full  = frc_o_q;

endmodule

/* design/bcc_ctrl.sv */
// ----------------------------------------------------------------------------
// bcc_ctrl: charge gauge sequencer
// Steps one word through prepare, seed divide, commit and percent divide,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module bcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  bcc_pkg::sts_t sts,
	output bcc_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_SMUL,
		ST_SDIV,
		ST_SWAIT,
		ST_COMMIT,
		ST_PMUL,
		ST_PDIV,
		ST_PWAIT,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.latch    = in_valid;
			ST_PREP:   cmd.prep     = 1'b1;
			ST_SMUL:   cmd.seed_mul = 1'b1;
			ST_SDIV: begin
				cmd.div_go   = 1'b1;
				cmd.div_long = 1'b1;
			end
			ST_SWAIT:  cmd.div_long = 1'b1;
			ST_COMMIT: cmd.commit   = 1'b1;
			ST_PMUL:   cmd.pct_mul  = 1'b1;
			ST_PDIV:   cmd.div_go   = 1'b1;
			ST_PWAIT:  cmd.div_go   = 1'b0;
			ST_DONE:   cmd.load_out = slot_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// new result replaces a taken one in the same cycle
			if (state_q == ST_DONE && slot_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:   if (in_valid) state_q <= ST_PREP;
				ST_PREP:   state_q <= sts.seed_div ? ST_SMUL : ST_COMMIT;
				ST_SMUL:   state_q <= ST_SDIV;
				ST_SDIV:   state_q <= ST_SWAIT;
				ST_SWAIT:  if (sts.div_done) state_q <= ST_COMMIT;
				ST_COMMIT: state_q <= sts.full_zero ? ST_DONE : ST_PMUL;
				ST_PMUL:   state_q <= ST_PDIV;
				ST_PDIV:   state_q <= ST_PWAIT;
				ST_PWAIT:  if (sts.div_done) state_q <= ST_DONE;
				ST_DONE:   if (slot_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* design/battery_coulomb_counter_unit.sv */
// ----------------------------------------------------------------------------
// battery_coulomb_counter_unit: coulomb counting battery charge gauge
// Seeds charge from a voltage table, integrates current, reports percent.
// ----------------------------------------------------------------------------
// Flow: a word is accepted only while the sequencer is idle; the next word
//   waits until the result is in the output register. The bit-serial divider
//   takes 28 steps for the seed and 14 for the percentage; a table seed alone
//   uses the seed divide, and zero capacity skips the percentage divide.
// Reset: arst_n clears the sequencer, the output valid flag and the stored
//   charge to zero; registers return to their documented defaults.
// ----------------------------------------------------------------------------
module battery_coulomb_counter_unit (
	input  logic                          clk,
	input  logic                          arst_n,

	// APB-style register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bcc_pkg::PADDR_W-1:0]   paddr,
	input  logic [bcc_pkg::PDATA_W-1:0]   pwdata,
	output logic [bcc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,

	// input word
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [bcc_pkg::VBAT_W-1:0]    vbat_mv,
	input  logic                          vbat_read_ok,
	input  logic [bcc_pkg::VBUS_W-1:0]    vbus_mv,
	input  logic [bcc_pkg::IBAT_W-1:0]    ibat_ma,
	input  logic                          charger_idle,

	// result word
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcc_pkg::PCT_W-1:0]     percent_x100,
	output logic [bcc_pkg::CHG_W-1:0]     charge_mas,
	output logic                          forced_full
);

	bcc_pkg::cfg_t cfg_q;
	bcc_pkg::cmd_t cmd;
	bcc_pkg::sts_t sts;
	logic          wr_en;
	logic [bcc_pkg::RIDX_W-1:0] ridx;

	// ------------------------------------------------------------------
	// Register file. Writes land on the access phase; pready is tied high
	// so no transfer waits. Config must only be changed by the user while
	// the gauge is idle (unenforced); the datapath reads it directly.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign ridx   = paddr[bcc_pkg::PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity_mah <= bcc_pkg::CAP_RST;
			cfg_q.deadband_ma  <= bcc_pkg::DB_RST;
			cfg_q.full_vbus_mv <= bcc_pkg::VBUS_RST;
			cfg_q.full_vbat_mv <= bcc_pkg::VBAT_RST;
			cfg_q.interval_s   <= bcc_pkg::IVL_RST;
		end else if (wr_en) begin
			unique case (ridx)
				bcc_pkg::REG_CAPACITY: cfg_q.capacity_mah <= pwdata[bcc_pkg::CAP_W-1:0];
				bcc_pkg::REG_DEADBAND: cfg_q.deadband_ma  <= pwdata[bcc_pkg::DB_W-1:0];
				bcc_pkg::REG_VBUS:     cfg_q.full_vbus_mv <= pwdata[bcc_pkg::VBUS_W-1:0];
				bcc_pkg::REG_VBAT:     cfg_q.full_vbat_mv <= pwdata[bcc_pkg::VBAT_W-1:0];
				bcc_pkg::REG_INTERVAL: cfg_q.interval_s   <= pwdata[bcc_pkg::IVL_W-1:0];
				default: ;  // unmapped addresses ignore writes
			endcase
		end
	end

	// read-back mux, zero for unmapped addresses
	always_comb begin
		unique case (ridx)
			bcc_pkg::REG_CAPACITY: prdata = {16'd0, cfg_q.capacity_mah};
			bcc_pkg::REG_DEADBAND: prdata = {24'd0, cfg_q.deadband_ma};
			bcc_pkg::REG_VBUS:     prdata = {17'd0, cfg_q.full_vbus_mv};
			bcc_pkg::REG_VBAT:     prdata = {19'd0, cfg_q.full_vbat_mv};
			bcc_pkg::REG_INTERVAL: prdata = {26'd0, cfg_q.interval_s};
			default:               prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: accepts a word only when idle. The output register holds
	// the previous word, so a new word is taken while the result waits; the
	// sequencer only stalls at the final step if the old result is unread.
	// ------------------------------------------------------------------
	bcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// ------------------------------------------------------------------
	// Datapath: charge held in mA-s. Seed = cap*36*numerator/span through
	// the shared divider, percent = charge*10000/(cap*3600) through it too.
	// ------------------------------------------------------------------
	bcc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.vbat_mv      (vbat_mv),
		.vbat_read_ok (vbat_read_ok),
		.vbus_mv      (vbus_mv),
		.ibat_ma      (ibat_ma),
		.charger_idle (charger_idle),
		.percent_x100 (percent_x100),
		.charge_mas   (charge_mas),
		.forced_full  (forced_full)
	);

endmodule

/* design/bcc_checker.sv */
// ----------------------------------------------------------------------------
// bcc_checker: port-level checks of the charge gauge
// Bound to the top level; watches the word channels only.
// ----------------------------------------------------------------------------
module bcc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [bcc_pkg::PCT_W-1:0]   percent_x100,
	input logic [bcc_pkg::CHG_W-1:0]   charge_mas,
	input logic                        forced_full
);

	// held result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// gauge is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while first in flight");

	// percent never exceeds full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> percent_x100 <= bcc_pkg::PCT_FULL)
		else $error("percent above full scale");

	// forced full reads 100 %, or zero charge with zero capacity
	a_forced_pct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && forced_full |->
			(percent_x100 == bcc_pkg::PCT_FULL) || (charge_mas == '0 && percent_x100 == '0))
		else $error("forced full without full percentage");

endmodule

bind battery_coulomb_counter_unit bcc_checker u_bcc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.percent_x100 (percent_x100),
	.charge_mas   (charge_mas),
	.forced_full  (forced_full)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the battery charge gauge
// Drives init and update words with random gaps and stalls, keeps a
// cycle-level-free model of the stored charge and checks every result word
// field by field. Config is reprogrammed between phases while the unit idles.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_WORDS   = 220;

	typedef logic [bcc_pkg::VBAT_W-1:0]        vbat_t;
	typedef logic [bcc_pkg::VBUS_W-1:0]        vbus_t;
	typedef logic signed [bcc_pkg::IBAT_W-1:0] ibat_t;

	typedef struct packed {
		logic  kind;
		vbat_t vbat;
		logic  read_ok;
		vbus_t vbus;
		ibat_t ibat;
		logic  idle;
	} gauge_word_t;

	typedef struct packed {
		logic [bcc_pkg::PCT_W-1:0] pct;
		logic [bcc_pkg::CHG_W-1:0] charge;
		logic                      forced;
	} soc_result_t;

	typedef struct packed {
		int mv;
		int pct;
	} ocv_point_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [bcc_pkg::PADDR_W-1:0]   paddr;
	logic [bcc_pkg::PDATA_W-1:0]   pwdata;
	logic [bcc_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic                          kind;
	logic [bcc_pkg::VBAT_W-1:0]    vbat_mv;
	logic                          vbat_read_ok;
	logic [bcc_pkg::VBUS_W-1:0]    vbus_mv;
	logic [bcc_pkg::IBAT_W-1:0]    ibat_ma;
	logic                          charger_idle;
	logic                          out_valid;
	logic                          out_stall;
	logic [bcc_pkg::PCT_W-1:0]     percent_x100;
	logic [bcc_pkg::CHG_W-1:0]     charge_mas;
	logic                          forced_full;

	// model copy of the registers and the stored charge
	int          cfg_capacity;
	int          cfg_deadband;
	int          cfg_vbus_thr;
	int          cfg_vbat_thr;
	int          cfg_interval;
	longint      stored_mas;

	soc_result_t soc_expected[$];
	int          fail_count  = 0;
	int          gap_pct     = 24;
	int          stall_pct   = 24;
	int          hold_cycles = 0;
	int          cycle_count = 0;

	battery_coulomb_counter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.vbat_mv      (vbat_mv),
		.vbat_read_ok (vbat_read_ok),
		.vbus_mv      (vbus_mv),
		.ibat_ma      (ibat_ma),
		.charger_idle (charger_idle),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.percent_x100 (percent_x100),
		.charge_mas   (charge_mas),
		.forced_full  (forced_full)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// OCV table, highest voltage first
	function automatic ocv_point_t ocv_point(input int i);
		ocv_point_t p;
		case (i)
		0: p = '{4200, 100};
		1: p = '{4100, 90};
		2: p = '{4000, 80};
		3: p = '{3900, 70};
		4: p = '{3800, 60};
		5: p = '{3700, 40};
		6: p = '{3600, 20};
		7: p = '{3500, 10};
		8: p = '{3300, 5};
		default: p = '{3000, 0};
		endcase
		return p;
	endfunction

	// advance the stored charge by one accepted word and queue its result
	task automatic predict_soc(input gauge_word_t w);
		longint      full_mas;
		longint      cap36;
		longint      cur;
		longint      next_mas;
		longint      span;
		longint      num;
		longint      pct;
		ocv_point_t  hi;
		ocv_point_t  lo;
		bit          found;
		soc_result_t r;
		full_mas = longint'(cfg_capacity) * 3600;
		cap36    = longint'(cfg_capacity) * 36;
		r.forced = 1'b0;
		if (w.kind == 1'b0) begin
			if (!w.read_ok)
				next_mas = full_mas / 2;
			else if (w.vbat >= 4200)
				next_mas = full_mas;
			else if (w.vbat <= 3000)
				next_mas = 0;
			else begin
				// interpolate inside the segment holding vbat
				found    = 1'b0;
				next_mas = 0;
				for (int i = 0; i < 9; i++) begin
					hi = ocv_point(i);
					lo = ocv_point(i + 1);
					if (!found && w.vbat >= lo.mv) begin
						found    = 1'b1;
						span     = longint'(hi.mv - lo.mv);
						num      = lo.pct * span
							+ (longint'(w.vbat) - lo.mv) * (hi.pct - lo.pct);
						next_mas = cap36 * num / span;
					end
				end
			end
			if (next_mas > full_mas)
				next_mas = full_mas;
		end else begin
			cur = longint'(w.ibat);
			if ((cur < 0 ? -cur : cur) < cfg_deadband)
				cur = 0;
			if (w.vbus > cfg_vbus_thr && w.idle && w.vbat > cfg_vbat_thr) begin
				next_mas = full_mas;
				r.forced = 1'b1;
			end else begin
				next_mas = stored_mas + cur * cfg_interval;
				if (next_mas > full_mas)
					next_mas = full_mas;
				if (next_mas < 0)
					next_mas = 0;
			end
		end
		stored_mas = next_mas;
		if (full_mas == 0)
			pct = 0;
		else begin
			pct = stored_mas * 10000 / full_mas;
			if (pct > 10000)
				pct = 10000;
		end
		r.pct    = pct[bcc_pkg::PCT_W-1:0];
		r.charge = stored_mas[bcc_pkg::CHG_W-1:0];
		soc_expected.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// valid stays up between back-to-back words; lowered only for a gap
	task automatic send_word(input gauge_word_t w);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		in_valid     <= 1'b1;
		kind         <= w.kind;
		vbat_mv      <= w.vbat;
		vbat_read_ok <= w.read_ok;
		vbus_mv      <= w.vbus;
		ibat_ma      <= w.ibat;
		charger_idle <= w.idle;
		do @(posedge clk); while (in_stall);
		predict_soc(w);
	endtask

	// drop valid and wait until every result word is back
	task automatic quiesce();
		in_valid <= 1'b0;
		while (soc_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [bcc_pkg::RIDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
		bcc_pkg::REG_CAPACITY: cfg_capacity = int'(val[bcc_pkg::CAP_W-1:0]);
		bcc_pkg::REG_DEADBAND: cfg_deadband = int'(val[bcc_pkg::DB_W-1:0]);
		bcc_pkg::REG_VBUS:     cfg_vbus_thr = int'(val[bcc_pkg::VBUS_W-1:0]);
		bcc_pkg::REG_VBAT:     cfg_vbat_thr = int'(val[bcc_pkg::VBAT_W-1:0]);
		bcc_pkg::REG_INTERVAL: cfg_interval = int'(val[bcc_pkg::IVL_W-1:0]);
		default: ;
		endcase
	endtask

	task automatic program_gauge(input int unsigned cap, input int unsigned db,
			input int unsigned vbus, input int unsigned vbat, input int unsigned ivl);
		quiesce();
		apb_write(bcc_pkg::REG_CAPACITY, cap);
		apb_write(bcc_pkg::REG_DEADBAND, db);
		apb_write(bcc_pkg::REG_VBUS, vbus);
		apb_write(bcc_pkg::REG_VBAT, vbat);
		apb_write(bcc_pkg::REG_INTERVAL, ivl);
	endtask

	function automatic gauge_word_t init_word(input int vbat, input bit ok);
		gauge_word_t w;
		w         = '0;
		w.kind    = 1'b0;
		w.vbat    = vbat_t'(vbat);
		w.read_ok = ok;
		return w;
	endfunction

	function automatic gauge_word_t update_word(input int vbat, input int vbus,
			input int ibat, input bit idle);
		gauge_word_t w;
		w      = '0;
		w.kind = 1'b1;
		w.vbat = vbat_t'(vbat);
		w.vbus = vbus_t'(vbus);
		w.ibat = ibat_t'(ibat);
		w.idle = idle;
		return w;
	endfunction

	// mostly near the thresholds and table, with some raw noise
	function automatic gauge_word_t random_word();
		gauge_word_t w;
		w.kind    = ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
		w.read_ok = ($urandom_range(0, 99) < 85);
		w.idle    = ($urandom_range(0, 1) == 1);
		case ($urandom_range(0, 2))
		0: w.vbat = vbat_t'($urandom_range(2950, 4250));
		1: w.vbat = vbat_t'(cfg_vbat_thr + int'($urandom_range(0, 4)) - 2);
		default: w.vbat = vbat_t'($urandom());
		endcase
		case ($urandom_range(0, 2))
		0: w.vbus = vbus_t'(cfg_vbus_thr + int'($urandom_range(0, 4)) - 2);
		1: w.vbus = vbus_t'($urandom_range(0, 25000));
		default: w.vbus = vbus_t'($urandom());
		endcase
		case ($urandom_range(0, 3))
		0: w.ibat = ibat_t'($urandom());
		1: w.ibat = ibat_t'((cfg_deadband + int'($urandom_range(0, 2)) - 1)
			* ($urandom_range(0, 1) ? 1 : -1));
		2: w.ibat = ibat_t'(int'($urandom_range(0, 60)) - 30);
		default: w.ibat = ibat_t'($urandom_range(0, 1) ? -4096 : 4095);
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Result check
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		soc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (soc_expected.size() == 0) begin
				$error("result word with nothing expected: percent_x100 %0d charge_mas %0d",
					percent_x100, charge_mas);
				fail_count++;
			end else begin
				want = soc_expected.pop_front();
				if (percent_x100 !== want.pct) begin
					$error("percent_x100: expected %0d, actual %0d", want.pct, percent_x100);
					fail_count++;
				end
				if (charge_mas !== want.charge) begin
					$error("charge_mas: expected %0d, actual %0d", want.charge, charge_mas);
					fail_count++;
				end
				if (forced_full !== want.forced) begin
					$error("forced_full: expected %0d, actual %0d", want.forced, forced_full);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stall: a long hold-off is counted here, otherwise random stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rx_stall
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles--;
		end else
			out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// table ends, segment edges, interpolation points, failed read
	task automatic test_voltage_seed();
		send_word(init_word(0, 1'b1));
		send_word(init_word(3000, 1'b1));
		send_word(init_word(3001, 1'b1));
		send_word(init_word(3250, 1'b1));
		send_word(init_word(3300, 1'b1));
		send_word(init_word(3650, 1'b1));
		send_word(init_word(3799, 1'b1));
		send_word(init_word(4150, 1'b1));
		send_word(init_word(4199, 1'b1));
		send_word(init_word(4200, 1'b1));
		send_word(init_word(8191, 1'b1));
		send_word(init_word(3650, 1'b0));
	endtask

	// deadband edge, current extremes, forced-full thresholds
	task automatic test_update_corners();
		send_word(update_word(3700, 0, 7, 1'b0));
		send_word(update_word(3700, 0, -8, 1'b0));
		send_word(update_word(3700, 0, 4095, 1'b0));
		send_word(update_word(3700, 0, -4096, 1'b1));
		send_word(update_word(4151, 4501, -4096, 1'b1));
		send_word(update_word(4151, 4500, 4095, 1'b1));
		send_word(update_word(8191, 32767, -4096, 1'b0));
		send_word(update_word(4150, 4501, 0, 1'b1));
	endtask

	// zero and out-of-range interval, capacity lowered after seeding, zero capacity
	task automatic test_config_corners();
		program_gauge(bcc_pkg::CAP_RST, bcc_pkg::DB_RST, bcc_pkg::VBUS_RST,
			bcc_pkg::VBAT_RST, 0);
		send_word(update_word(3700, 0, 4095, 1'b0));
		program_gauge(bcc_pkg::CAP_RST, bcc_pkg::DB_RST, bcc_pkg::VBUS_RST,
			bcc_pkg::VBAT_RST, 63);
		send_word(update_word(3700, 0, -4096, 1'b0));
		program_gauge(65535, 0, 25000, 8191, 1);
		send_word(init_word(8191, 1'b1));
		program_gauge(100, 255, 25000, 8191, 1);
		send_word(update_word(3700, 0, 254, 1'b0));
		program_gauge(0, 8, 4500, 4150, 1);
		send_word(update_word(3700, 0, 4095, 1'b0));
		send_word(init_word(4000, 1'b1));
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
			0: program_gauge(bcc_pkg::CAP_RST, bcc_pkg::DB_RST, bcc_pkg::VBUS_RST,
				bcc_pkg::VBAT_RST, bcc_pkg::IVL_RST);
			1: program_gauge(1, 0, 0, 0, 60);
			2: program_gauge(65535, 255, 25000, 8191, 60);
			3: program_gauge(0, 8, 4500, 4150, 30);
			default: program_gauge($urandom_range(1, 2000), $urandom_range(0, 255),
				$urandom_range(0, 25000), $urandom_range(2900, 4300),
				$urandom_range(1, 60));
			endcase
			repeat (PHASE_WORDS)
				send_word(random_word());
		end
	endtask

	// no gaps and no stalls at all
	task automatic test_steady_stream();
		gap_pct   = 0;
		stall_pct = 0;
		repeat (200)
			send_word(random_word());
		gap_pct   = 24;
		stall_pct = 24;
	endtask

	// receiver holds off long enough that the unit backs up into its input
	task automatic test_backpressure();
		hold_cycles = 400;
		repeat (60)
			send_word(random_word());
	endtask

	initial begin
		arst_n       <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		in_valid     <= 1'b0;
		kind         <= 1'b0;
		vbat_mv      <= '0;
		vbat_read_ok <= 1'b0;
		vbus_mv      <= '0;
		ibat_ma      <= '0;
		charger_idle <= 1'b0;
		out_stall    <= 1'b0;
		cfg_capacity = int'(bcc_pkg::CAP_RST);
		cfg_deadband = int'(bcc_pkg::DB_RST);
		cfg_vbus_thr = int'(bcc_pkg::VBUS_RST);
		cfg_vbat_thr = int'(bcc_pkg::VBAT_RST);
		cfg_interval = int'(bcc_pkg::IVL_RST);
		stored_mas   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_voltage_seed();
		test_update_corners();
		test_config_corners();
		test_random_traffic();
		test_steady_stream();
		test_backpressure();

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* battery_coulomb_counter_unit.f */
design/bcc_pkg.sv
design/bcc_div.sv
design/bcc_dp.sv
design/bcc_ctrl.sv
design/battery_coulomb_counter_unit.sv
design/bcc_checker.sv
sim/testbench.sv
